@@ hdl/ssort_pkg.sv @@
package ssort_pkg;

    // Default store depth and data width
    localparam int STORE_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PLACE
    } ssort_state_t;

    // Control from the sequencer to the minimum unit
    typedef struct packed {
        logic valid;   // read data of this cycle takes part in the search
        logic first;   // read data is the head of the unsorted rest
    } ssort_cmp_t;

endpackage

@@ hdl/ssort_store.sv @@
module ssort_store import ssort_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ssort_min_unit.sv @@
module ssort_min_unit import ssort_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  logic              aclk,
    input  ssort_cmp_t        cmp,
    input  logic [DATA_W-1:0] rd_data,
    input  logic [IDX_W-1:0]  rd_at,
    output logic [DATA_W-1:0] best,
    output logic [IDX_W-1:0]  best_at,
    output logic [DATA_W-1:0] head_val
);

    logic [DATA_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_at_reg;
    logic [DATA_W-1:0] head_val_reg;
    logic              less;

    // Strict signed compare keeps the first of equal minima
    assign less = $signed(rd_data) < $signed(best_reg);

    // Track the running minimum and the value at the head position
    always_ff @(posedge aclk) begin
        if (cmp.valid) begin
            if (cmp.first || less) begin
                best_reg    <= rd_data;
                best_at_reg <= rd_at;
            end
            if (cmp.first) begin
                head_val_reg <= rd_data;
            end
        end
    end

    assign best     = best_reg;
    assign best_at  = best_at_reg;
    assign head_val = head_val_reg;

endmodule

@@ hdl/ssort_ctrl.sv @@
module ssort_ctrl import ssort_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_element,
    input  logic              s_set_end,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_sorted_value,
    output logic              m_final_out,
    output logic              m_overflowed,
    // store ports
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    // minimum unit
    output ssort_cmp_t        cmp,
    output logic [IDX_W-1:0]  rd_at,
    input  logic [DATA_W-1:0] best,
    input  logic [IDX_W-1:0]  best_at,
    input  logic [DATA_W-1:0] head_val
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    ssort_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_at_reg, pend_at_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              slot_free;
    logic              in_xfer;
    logic              has_room;
    logic              last_pos;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_xfer   = s_tvalid && s_tready;
    assign has_room  = fill_reg < DEPTH_C;
    assign last_pos  = (pos_reg == (count_reg - ONE_C));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Counters and result payload
    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        pos_reg       <= pos_next;
        scan_reg      <= scan_next;
        pend_at_reg   <= pend_at_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Sequencer: load, scan for the minimum, place it and emit it
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_at_next   = pend_at_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[IDX_W-1:0];
        wr_data        = s_element;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IDX_W-1:0];

        // drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (has_room) begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + ONE_C;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_set_end) begin
                        count_next = has_room ? (fill_reg + ONE_C) : fill_reg;
                        pos_next   = '0;
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read a cycle over the unsorted rest
                if (scan_reg < count_reg) begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    pend_at_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + ONE_C;
                end else if (!pend_reg) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                // move the head value to the minimum's slot and emit the minimum
                if (slot_free) begin
                    wr_en          = 1'b1;
                    wr_addr        = best_at;
                    wr_data        = head_val;
                    out_valid_next = 1'b1;
                    out_value_next = best;
                    out_last_next  = last_pos;
                    out_ovf_next   = ovf_reg;
                    if (last_pos) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        pos_next   = pos_reg + ONE_C;
                        scan_next  = pos_reg + ONE_C;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign cmp.valid = pend_reg;
    assign cmp.first = (pend_at_reg == pos_reg[IDX_W-1:0]);
    assign rd_at     = pend_at_reg;

    assign m_tvalid       = out_valid_reg;
    assign m_sorted_value = out_value_reg;
    assign m_final_out    = out_last_reg;
    assign m_overflowed   = out_ovf_reg;

endmodule

@@ hdl/selection_sort_engine_top.sv @@
// Values are loaded while s_tready is high; the set-closing transfer starts the sort.
// Sorting n stored values runs one shared signed compare unit over a store with one
// write and one read port: for each position p it scans slots p to n-1 for the
// minimum, then places it; m_tready held low stalls the place step.
// s_tready stays low from the set-closing transfer until the last result is loaded.
// aresetn (synchronous, active low) empties the set; the store is not cleared.
module selection_sort_engine_top import ssort_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element
    input  logic        s_tlast,   // set_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // final_out
    output logic        m_tuser    // [0] overflowed
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    ssort_cmp_t        cmp;
    logic [IDX_W-1:0]  rd_at;
    logic [DATA_W-1:0] best;
    logic [IDX_W-1:0]  best_at;
    logic [DATA_W-1:0] head_val;

    ssort_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssort_min_unit #(
        .IDX_W (IDX_W)
    ) u_min (
        .aclk     (aclk),
        .cmp      (cmp),
        .rd_data  (rd_data),
        .rd_at    (rd_at),
        .best     (best),
        .best_at  (best_at),
        .head_val (head_val)
    );

    ssort_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_element      (s_tdata),
        .s_set_end      (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_sorted_value (m_tdata),
        .m_final_out    (m_tlast),
        .m_overflowed   (m_tuser),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .cmp            (cmp),
        .rd_at          (rd_at),
        .best           (best),
        .best_at        (best_at),
        .head_val       (head_val)
    );

endmodule
